@@ design/cscan_pkg.sv @@
// shared constants and types for the c-scan request scheduler
package cscan_pkg;

   localparam int MAX_REQUESTS   = 32;
   localparam int CYLINDER_BITS  = 16;
   localparam int MOVE_BITS      = CYLINDER_BITS + 2;
   localparam int REQ_ADDR_BITS  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int COUNT_BITS     = $clog2(MAX_REQUESTS + 1);
   localparam int REQ_TDATA_BITS = ((CYLINDER_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((CYLINDER_BITS + MOVE_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = CYLINDER_BITS + 1;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_HEAD   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DISK_SIZE    = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_DIRECTION_UP = 2'd2;

   typedef logic [CYLINDER_BITS-1:0] cyl_type;
   typedef logic [MOVE_BITS-1:0]     move_type;
   typedef logic [COUNT_BITS-1:0]    count_type;
   typedef logic [REQ_ADDR_BITS-1:0] addr_type;

endpackage

@@ design/cscan_ram.sv @@
// generic single write, single read ram with registered read data
module cscan_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/cscan_disk_request_scheduler_unit.sv @@
// c-scan disk request scheduler: batch load, in-place sort, split search and service walk
//
// usage
//   req channel: one cylinder request per transfer in req_tdata, one per cycle while
//   req_tready is high; the transfer with req_tlast set closes the batch and starts work.
//   requests beyond the outer edge are clamped, and past the batch capacity they are
//   dropped (a tlast still starts scheduling).
//   rsp channel: the c-scan visit order, one cylinder per transfer with the running head
//   movement; rsp_tuser flags a disk edge, rsp_tlast marks the final visit of the batch.
//   csr channel: always ready; write start head, disk size and sweep direction while idle.
// sequence
//   each accepted request is written to the ram. after tlast the batch is sorted by
//   insertion on the request ram (one read port, one write port), one request at a time.
//   the split search then reads and compares the sorted entries in turn, the walk is set
//   up, and each visit passes a select, a difference and an accumulate step on the shared
//   abs-difference / accumulate path; one more select step leaves the first run.
//   req_tready stays low from the tlast transfer until the final visit is registered.
// reset: synchronous; clears the batch, the output register and the registers to
//   start head 0, disk size 2^16, upward sweep. ram contents are not cleared.
// stall: a visit waits in its accumulate step while rsp_tvalid is high and rsp_tready
//   low; the output register holds its transfer until taken.
module cscan_disk_request_scheduler_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // cylinder request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [cscan_pkg::REQ_TDATA_BITS-1:0]   req_tdata,   // cylinder
   input  logic                                   req_tlast,   // last request of the batch
   // service order stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [cscan_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,   // position, running_movement
   output logic                                   rsp_tuser,   // is_boundary
   output logic                                   rsp_tlast,   // end of sequence
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [cscan_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [cscan_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import cscan_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SORT_RD, ST_SORT_V, ST_SCAN_RD, ST_SCAN_CMP, ST_SPLIT_RD,
      ST_SPLIT_CMP, ST_EMIT_INIT, ST_SEL, ST_DIFF, ST_ACC
   } state_type;

   // visit segments in service order
   typedef enum logic [1:0] {
      SEG_FIRST, SEG_EDGE_A, SEG_EDGE_B, SEG_SECOND
   } seg_type;

   // configuration
   cyl_type                start_head_ff;
   logic [CSR_DATA_BITS-1:0] disk_size_ff;
   logic                   dir_up_ff;

   // sequencer
   state_type  state_ff;
   seg_type    seg_ff;
   count_type  count_ff;
   count_type  i_ff;
   count_type  j_ff;
   count_type  split_ff;
   count_type  cur_ff;
   cyl_type    v_ff;
   logic       last_ff;
   logic       from_ram_ff;
   cyl_type    const_ff;

   // movement path
   cyl_type    pos_ff;
   cyl_type    diff_ff;
   cyl_type    head_ff;
   move_type   sum_ff;

   // output register
   logic       rsp_valid_ff;
   cyl_type    rsp_pos_ff;
   logic       rsp_bnd_ff;
   move_type   rsp_move_ff;
   logic       rsp_last_ff;

   // ram ports
   logic       wr_en;
   addr_type   wr_addr;
   cyl_type    wr_data;
   addr_type   rd_addr;
   cyl_type    rd_data;

   logic [CSR_DATA_BITS-1:0] ds_m1;
   cyl_type    edge_cyl;
   cyl_type    req_cyl;
   cyl_type    clamp_cyl;
   logic       accept_req;
   logic       batch_full;
   count_type  load_count;
   count_type  i_next;
   count_type  j_m1;
   logic       cmp_gt;
   count_type  seg1_lo, seg1_hi, seg4_lo, seg4_hi;
   count_type  cur_lo, cur_hi, cur_end, cur_next, cur_m1;
   cyl_type    pos_sel;
   cyl_type    abs_diff;
   logic [MOVE_BITS:0] sum_wide;
   move_type   sum_sat;
   logic       out_free;

   // outer edge: size zero acts as one cylinder, oversize clamps to the full range
   assign ds_m1    = disk_size_ff - 1'b1;
   assign edge_cyl = (disk_size_ff == '0)          ? '0 :
                     disk_size_ff[CYLINDER_BITS]   ? '1 : ds_m1[CYLINDER_BITS-1:0];

   assign req_cyl    = req_tdata[CYLINDER_BITS-1:0];
   assign clamp_cyl  = (req_cyl > edge_cyl) ? edge_cyl : req_cyl;
   assign req_tready = (state_ff == ST_LOAD);
   assign accept_req = req_tvalid && req_tready;
   assign batch_full = (count_ff >= COUNT_BITS'(MAX_REQUESTS));
   assign load_count = batch_full ? count_ff : count_ff + 1'b1;

   assign i_next = i_ff + 1'b1;
   assign j_m1   = j_ff - 1'b1;

   // shared comparator: sort compares against the held key, split against the head
   assign cmp_gt = rd_data > ((state_ff == ST_SPLIT_CMP) ? start_head_ff : v_ff);

   // list segment bounds: upward walks [split,n) then [0,split), downward the mirror
   assign seg1_lo = dir_up_ff ? split_ff : '0;
   assign seg1_hi = dir_up_ff ? count_ff : split_ff;
   assign seg4_lo = dir_up_ff ? '0       : split_ff;
   assign seg4_hi = dir_up_ff ? split_ff : count_ff;
   assign cur_lo  = (seg_ff == SEG_FIRST) ? seg1_lo : seg4_lo;
   assign cur_hi  = (seg_ff == SEG_FIRST) ? seg1_hi : seg4_hi;
   assign cur_end = dir_up_ff ? cur_hi : cur_lo;
   assign cur_m1  = cur_ff - 1'b1;
   assign cur_next = dir_up_ff ? cur_ff + 1'b1 : cur_m1;

   // shared distance and saturating accumulate
   assign pos_sel  = from_ram_ff ? rd_data : const_ff;
   assign abs_diff = (pos_sel >= head_ff) ? pos_sel - head_ff : head_ff - pos_sel;
   assign sum_wide = {1'b0, sum_ff} + (MOVE_BITS + 1)'(diff_ff);
   assign sum_sat  = sum_wide[MOVE_BITS] ? '1 : sum_wide[MOVE_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ram port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = clamp_cyl;
      rd_addr = '0;
      case (state_ff)
         ST_LOAD: begin
            wr_en   = accept_req && !batch_full;
            wr_addr = count_ff[REQ_ADDR_BITS-1:0];
         end
         ST_SORT_RD: begin
            rd_addr = i_ff[REQ_ADDR_BITS-1:0];
         end
         ST_SCAN_RD: begin
            wr_en   = (j_ff == '0);
            wr_data = v_ff;
            rd_addr = j_m1[REQ_ADDR_BITS-1:0];
         end
         ST_SCAN_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[REQ_ADDR_BITS-1:0];
            wr_data = cmp_gt ? rd_data : v_ff;
         end
         ST_SPLIT_RD: begin
            rd_addr = i_ff[REQ_ADDR_BITS-1:0];
         end
         ST_SEL: begin
            rd_addr = dir_up_ff ? cur_ff[REQ_ADDR_BITS-1:0] : cur_m1[REQ_ADDR_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   cscan_ram #(
      .WIDTH (CYLINDER_BITS),
      .DEPTH (MAX_REQUESTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         start_head_ff <= '0;
         disk_size_ff  <= CSR_DATA_BITS'(1) << CYLINDER_BITS;
         dir_up_ff     <= 1'b1;
         state_ff      <= ST_LOAD;
         seg_ff        <= SEG_FIRST;
         count_ff      <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         split_ff      <= '0;
         cur_ff        <= '0;
         last_ff       <= 1'b0;
         from_ram_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // register writes, to be issued by the user only while idle; the block does not enforce it
         if (csr_valid) begin
            case (csr_addr)
               CSR_START_HEAD:   start_head_ff <= csr_wdata[CYLINDER_BITS-1:0];
               CSR_DISK_SIZE:    disk_size_ff  <= csr_wdata;
               CSR_DIRECTION_UP: dir_up_ff     <= csr_wdata[0];
               default: begin
               end
            endcase
         end

         // a new visit refills the output register, otherwise a taken transfer empties it
         if ((state_ff == ST_ACC) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_LOAD: begin
               if (accept_req) begin
                  count_ff <= load_count;
                  if (req_tlast) begin
                     if (load_count > COUNT_BITS'(1)) begin
                        i_ff     <= COUNT_BITS'(1);
                        state_ff <= ST_SORT_RD;
                     end else begin
                        i_ff     <= '0;
                        state_ff <= ST_SPLIT_RD;
                     end
                  end
               end
            end
            ST_SORT_RD: begin
               state_ff <= ST_SORT_V;
            end
            ST_SORT_V: begin
               v_ff     <= rd_data;
               j_ff     <= i_ff;
               state_ff <= ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
               // key at slot zero is already written by the ram steering
               if (j_ff == '0) begin
                  if (i_next == count_ff) begin
                     i_ff     <= '0;
                     state_ff <= ST_SPLIT_RD;
                  end else begin
                     i_ff     <= i_next;
                     state_ff <= ST_SORT_RD;
                  end
               end else begin
                  state_ff <= ST_SCAN_CMP;
               end
            end
            ST_SCAN_CMP: begin
               if (cmp_gt) begin
                  j_ff     <= j_m1;
                  state_ff <= ST_SCAN_RD;
               end else if (i_next == count_ff) begin
                  i_ff     <= '0;
                  state_ff <= ST_SPLIT_RD;
               end else begin
                  i_ff     <= i_next;
                  state_ff <= ST_SORT_RD;
               end
            end
            ST_SPLIT_RD: begin
               state_ff <= ST_SPLIT_CMP;
            end
            ST_SPLIT_CMP: begin
               // no request above the head leaves the split at the batch count
               if (cmp_gt) begin
                  split_ff <= i_ff;
                  state_ff <= ST_EMIT_INIT;
               end else if (i_next == count_ff) begin
                  split_ff <= count_ff;
                  state_ff <= ST_EMIT_INIT;
               end else begin
                  i_ff     <= i_next;
                  state_ff <= ST_SPLIT_RD;
               end
            end
            ST_EMIT_INIT: begin
               seg_ff   <= SEG_FIRST;
               cur_ff   <= dir_up_ff ? seg1_lo : seg1_hi;
               head_ff  <= start_head_ff;
               sum_ff   <= '0;
               state_ff <= ST_SEL;
            end
            ST_SEL: begin
               case (seg_ff)
                  SEG_FIRST, SEG_SECOND: begin
                     if (cur_ff == cur_end) begin
                        if (seg_ff == SEG_FIRST) begin
                           seg_ff <= SEG_EDGE_A;
                        end else begin
                           count_ff <= '0;
                           state_ff <= ST_LOAD;
                        end
                     end else begin
                        from_ram_ff <= 1'b1;
                        cur_ff      <= cur_next;
                        last_ff     <= (seg_ff == SEG_SECOND) && (cur_next == cur_end);
                        state_ff    <= ST_DIFF;
                     end
                  end
                  SEG_EDGE_A: begin
                     from_ram_ff <= 1'b0;
                     const_ff    <= dir_up_ff ? edge_cyl : '0;
                     last_ff     <= 1'b0;
                     seg_ff      <= SEG_EDGE_B;
                     state_ff    <= ST_DIFF;
                  end
                  SEG_EDGE_B: begin
                     from_ram_ff <= 1'b0;
                     const_ff    <= dir_up_ff ? '0 : edge_cyl;
                     last_ff     <= (seg4_lo == seg4_hi);
                     seg_ff      <= SEG_SECOND;
                     cur_ff      <= dir_up_ff ? seg4_lo : seg4_hi;
                     state_ff    <= ST_DIFF;
                  end
                  default: begin
                     state_ff <= ST_LOAD;
                  end
               endcase
            end
            ST_DIFF: begin
               pos_ff   <= pos_sel;
               diff_ff  <= abs_diff;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               // hold here while the previous transfer is still waiting
               if (out_free) begin
                  rsp_pos_ff   <= pos_ff;
                  rsp_bnd_ff   <= (pos_ff == '0) || (pos_ff == edge_cyl);
                  rsp_move_ff  <= sum_sat;
                  rsp_last_ff  <= last_ff;
                  sum_ff       <= sum_sat;
                  head_ff      <= pos_ff;
                  if (last_ff) begin
                     count_ff <= '0;
                     state_ff <= ST_LOAD;
                  end else begin
                     state_ff <= ST_SEL;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_move_ff, rsp_pos_ff});
   assign rsp_tuser  = rsp_bnd_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ design/cscan_checker.sv @@
// port-level checks for the c-scan request scheduler, bound to the top level
module cscan_port_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 req_tlast,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [cscan_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                 rsp_tuser,
   input logic                                 rsp_tlast
);
   import cscan_pkg::*;

   // batch close starts scheduling, so no request is taken on the next cycle
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("request taken right after batch close");

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("result changed while stalled");

   // cylinder zero is always a disk edge
   a_zero_is_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[CYLINDER_BITS-1:0] == '0)) |-> rsp_tuser)
      else $error("cylinder zero not flagged as edge");

   // reset empties the output and reopens loading
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("block not idle after reset");

endmodule

bind cscan_disk_request_scheduler_unit cscan_port_checker u_cscan_checker (.*);

@@ tb/cscan_checker.sv @@
// service-order predictor and result checker for the c-scan request scheduler
module cscan_checker
   import cscan_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   input  logic                      req_tlast,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      rsp_tuser,
   input  logic                      rsp_tlast,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        pending_count,
   output int                        visit_count
);

   typedef struct {
      cyl_type  position;
      logic     is_boundary;
      move_type movement;
      logic     end_of_seq;
   } visit_type;

   localparam int unsigned MOVE_LIMIT = (1 << MOVE_BITS) - 1;
   localparam int unsigned CYL_SPAN   = 1 << CYLINDER_BITS;

   cyl_type                  start_head_reg;
   logic [CSR_DATA_BITS-1:0] disk_size_reg;
   logic                     direction_up_reg;
   cyl_type                  batch_q[$];
   visit_type                visit_q[$];
   int unsigned              head_pos;
   int unsigned              move_total;
   visit_type                want;
   cyl_type                  load_cyl;

   function automatic cyl_type outer_edge_of(input logic [CSR_DATA_BITS-1:0] size);
      int unsigned span;
      span = size;
      if (span == 0) span = 1;
      if (span > CYL_SPAN) span = CYL_SPAN;
      return cyl_type'(span - 1);
   endfunction

   task automatic add_visit(input cyl_type pos, input cyl_type edge_cyl);
      visit_type   v;
      int unsigned step;
      step = (pos > head_pos) ? pos - head_pos : head_pos - pos;
      move_total = move_total + step;
      if (move_total > MOVE_LIMIT) move_total = MOVE_LIMIT;
      head_pos = pos;
      v.position    = pos;
      v.is_boundary = (pos == 0) || (pos == edge_cyl);
      v.movement    = move_type'(move_total);
      v.end_of_seq  = 1'b0;
      visit_q.push_back(v);
   endtask

   // sort the batch, find the split and queue the whole sweep
   task automatic plan_service();
      cyl_type   sorted[$];
      cyl_type   key;
      cyl_type   edge_cyl;
      visit_type tail;
      int        n, split, i, j;
      edge_cyl = outer_edge_of(disk_size_reg);
      sorted = batch_q;
      n = sorted.size();
      for (i = 1; i < n; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      split = n;
      for (i = n - 1; i >= 0; i--) begin
         if (sorted[i] > start_head_reg) split = i;
      end
      head_pos   = start_head_reg;
      move_total = 0;
      if (direction_up_reg) begin
         for (i = split; i < n; i++) add_visit(sorted[i], edge_cyl);
         add_visit(edge_cyl, edge_cyl);
         add_visit('0, edge_cyl);
         for (i = 0; i < split; i++) add_visit(sorted[i], edge_cyl);
      end else begin
         for (i = split; i > 0; i--) add_visit(sorted[i-1], edge_cyl);
         add_visit('0, edge_cyl);
         add_visit(edge_cyl, edge_cyl);
         for (i = n; i > split; i--) add_visit(sorted[i-1], edge_cyl);
      end
      tail = visit_q.pop_back();
      tail.end_of_seq = 1'b1;
      visit_q.push_back(tail);
      batch_q.delete();
   endtask

   task automatic report_field(input string name, input int unsigned exp_val,
                               input int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s expected %0d actual %0d", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_head_reg   = '0;
         disk_size_reg    = CSR_DATA_BITS'(CYL_SPAN);
         direction_up_reg = 1'b1;
         batch_q.delete();
         visit_q.delete();
         fail_count  = 0;
         visit_count = 0;
      end else begin
         // results first so a batch closing this cycle cannot absorb them
         if (rsp_tvalid && rsp_tready) begin
            if (visit_q.size() == 0) begin
               $error("unexpected result position %0d", rsp_tdata[CYLINDER_BITS-1:0]);
               fail_count++;
            end else begin
               want = visit_q.pop_front();
               report_field("position", want.position, rsp_tdata[CYLINDER_BITS-1:0]);
               report_field("is_boundary", want.is_boundary, rsp_tuser);
               report_field("running_movement", want.movement,
                            rsp_tdata[CYLINDER_BITS +: MOVE_BITS]);
               report_field("end_of_sequence", want.end_of_seq, rsp_tlast);
               visit_count++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_START_HEAD:   start_head_reg   = csr_wdata[CYLINDER_BITS-1:0];
               CSR_DISK_SIZE:    disk_size_reg    = csr_wdata;
               CSR_DIRECTION_UP: direction_up_reg = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            load_cyl = req_tdata[CYLINDER_BITS-1:0];
            if (load_cyl > outer_edge_of(disk_size_reg)) load_cyl = outer_edge_of(disk_size_reg);
            if (batch_q.size() < MAX_REQUESTS) batch_q.push_back(load_cyl);
            if (req_tlast) plan_service();
         end
      end
      pending_count = visit_q.size();
   end

endmodule

@@ tb/testbench.sv @@
// stimulus and verdict for the c-scan request scheduler
module testbench;
   import cscan_pkg::*;

   // address with no register behind it, writes must be ignored
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int PHASE_ITEMS = 78;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_ADDR_BITS-1:0]  csr_addr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;
   int visit_count;

   // stimulus knobs, read by the sender and receiver processes
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_request   = 0;
   int idle_table[4]  = '{0, 80, 0, 25};
   int stall_table[4] = '{0, 0, 80, 25};

   // mirror of the programmed registers, only used to aim the cylinders
   int cur_head = 0;
   int cur_edge = 65535;

   int items_sent   = 0;
   int batches_sent = 0;
   int csr_writes   = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cscan_disk_request_scheduler_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   cscan_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .visit_count   (visit_count)
   );

   // receiver: random stalls, or a long hold-off counted here when requested
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // one register transfer on the csr channel
   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic set_registers(input int head, input int size, input logic up);
      write_register(CSR_START_HEAD, CSR_DATA_BITS'(head));
      write_register(CSR_DISK_SIZE, CSR_DATA_BITS'(size));
      write_register(CSR_DIRECTION_UP, CSR_DATA_BITS'(up));
      cur_head = head;
      if (size == 0) cur_edge = 0;
      else if (size > 65536) cur_edge = 65535;
      else cur_edge = size - 1;
   endtask

   // valid stays high across back-to-back transfers, lowered only on an idle cycle
   task automatic send_request(input int cyl, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(cyl);
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (last) batches_sent++;
   endtask

   // stop offering, let every visit come out, then leave idle slack before returning
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic int pick_cylinder();
      int r;
      r = $urandom_range(99);
      if (r < 40) return $urandom_range(65535);
      else if (r < 55) return $urandom_range(cur_edge);
      else if (r < 70) return (cur_head + $urandom_range(6) - 3) & 16'hffff;
      else if (r < 78) return 0;
      else if (r < 86) return 65535;
      else return cur_edge;
   endfunction

   // mostly short batches, now and then one that overruns the capacity
   function automatic int pick_batch_length();
      int r;
      r = $urandom_range(99);
      if (r < 5) return $urandom_range(MAX_REQUESTS + 1, MAX_REQUESTS + 4);
      else if (r < 15) return 1;
      else return $urandom_range(2, 8);
   endfunction

   task automatic pick_registers();
      int size, head;
      case ($urandom_range(9))
         0: size = 0;
         1: size = 1;
         2: size = 65536;
         3: size = 131071;
         4, 5: size = $urandom_range(2, 300);
         default: size = $urandom_range(131071);
      endcase
      case ($urandom_range(7))
         0: head = 0;
         1: head = 65535;
         2: head = (size == 0) ? 0 : ((size > 65536) ? 65535 : size - 1);
         3, 4: head = $urandom_range(320);
         default: head = $urandom_range(65535);
      endcase
      set_registers(head, size, 1'($urandom_range(1)));
   endtask

   task automatic send_batch(input int n);
      for (int i = 0; i < n; i++) send_request(pick_cylinder(), i == n - 1);
   endtask

   initial begin
      int  phase_start;
      bit  pressure_done;
      pressure_done = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: reset register values, single request at cylinder zero
      send_request(0, 1'b1);
      // extremes and a duplicate
      send_request(65535, 1'b0);
      send_request(0, 1'b0);
      send_request(30000, 1'b0);
      send_request(30000, 1'b1);
      wait_for_drain();
      // nothing above the head, downward sweep
      set_registers(65535, 65536, 1'b0);
      send_request(100, 1'b0);
      send_request(65535, 1'b0);
      send_request(5, 1'b1);
      wait_for_drain();
      // disk size zero collapses to one cylinder, head far beyond the edge
      set_registers(65535, 0, 1'b1);
      send_request(70, 1'b0);
      send_request(0, 1'b1);
      wait_for_drain();
      // oversized disk is capped at the full cylinder range
      set_registers(0, 131071, 1'b0);
      send_request(65535, 1'b0);
      send_request(1, 1'b1);
      wait_for_drain();
      // clamping on load and requests equal to the head
      set_registers(500, 1000, 1'b0);
      send_request(999, 1'b0);
      send_request(1500, 1'b0);
      send_request(500, 1'b0);
      send_request(501, 1'b0);
      send_request(0, 1'b1);
      wait_for_drain();
      // write to the spare index must leave the registers alone
      write_register(CSR_SPARE_INDEX, '1);
      set_registers(500, 1000, 1'b1);
      send_request(501, 1'b0);
      send_request(499, 1'b0);
      send_request(500, 1'b1);
      wait_for_drain();

      // random batches under each idling mix
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_table[p];
         recv_stall_pct = stall_table[p];
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(2) == 0) begin
               wait_for_drain();
               pick_registers();
            end
            // long receiver hold while the next batches keep coming
            if (p == 0 && !pressure_done && items_sent - phase_start > 20) begin
               hold_request = 400;
               pressure_done = 1;
            end
            send_batch(pick_batch_length());
         end
         wait_for_drain();
      end

      repeat (20) @(negedge clock);
      $display("covered %0d requests in %0d batches, %0d register writes, %0d visits checked",
               items_sent, batches_sent, csr_writes, visit_count);
      $display("idle mixes none, sender 80, receiver 80, both 25, plus one long output hold");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
